### hdl/ndg_pkg.sv
// -----------------------------------------------------------------------------
// ndg_pkg
// Types and constants shared by the nearest-neighbor gray downscaler.
// -----------------------------------------------------------------------------
package ndg_pkg;

	// Color channel and configuration widths.
	localparam int CHAN_W    = 8;
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 2;

	// Sum of three channels and the reciprocal used to divide it by three.
	// 683 / 2048 is close enough to 1/3 that the floor is exact for sums up to 765.
	localparam int SUM_W        = 10;
	localparam int RECIP3       = 683;
	localparam int RECIP3_SHIFT = 11;
	localparam int PROD_W       = 20;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SRC_WIDTH  = 2'd0,
		REG_SRC_HEIGHT = 2'd1,
		REG_DST_WIDTH  = 2'd2,
		REG_DST_HEIGHT = 2'd3
	} cfg_reg_t;

	// Register reset values.
	localparam logic [CFG_W-1:0] SRC_WIDTH_RST  = 13'd640;
	localparam logic [CFG_W-1:0] SRC_HEIGHT_RST = 13'd480;
	localparam logic [CFG_W-1:0] DST_WIDTH_RST  = 13'd64;
	localparam logic [CFG_W-1:0] DST_HEIGHT_RST = 13'd64;

	// A sampled pixel waiting for its gray conversion.
	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic              frame_end;
	} sample_t;

endpackage

### hdl/ndg_rgb_if.sv
// -----------------------------------------------------------------------------
// ndg_rgb_if
// Valid/ready channel that carries one RGB source pixel per transfer.
// -----------------------------------------------------------------------------
interface ndg_rgb_if;

	logic                       valid;
	logic                       ready;
	logic [ndg_pkg::CHAN_W-1:0] red;
	logic [ndg_pkg::CHAN_W-1:0] green;
	logic [ndg_pkg::CHAN_W-1:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink   (input valid, input red, input green, input blue, output ready);

endinterface

### hdl/ndg_mono_if.sv
// -----------------------------------------------------------------------------
// ndg_mono_if
// Valid/ready channel that carries one gray output pixel per transfer.
// -----------------------------------------------------------------------------
interface ndg_mono_if;

	logic                       valid;
	logic                       ready;
	logic [ndg_pkg::CHAN_W-1:0] gray;
	logic                       frame_end;

	modport source (output valid, output gray, output frame_end, input ready);
	modport sink   (input valid, input gray, input frame_end, output ready);

endinterface

### hdl/ndg_divider.sv
// -----------------------------------------------------------------------------
// ndg_divider
// Restoring divider that produces one quotient bit per cycle.
// -----------------------------------------------------------------------------
module ndg_divider #(
	parameter int W = 13
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         busy,
	output logic [W-1:0] quotient,
	output logic [W-1:0] remainder
);

	localparam int CNT_W = $clog2(W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     quo_q;
	logic [W-1:0]     rem_q;
	logic [W-1:0]     divisor_q;
	logic [W:0]       rem_shift;
	logic [W:0]       rem_diff;
	logic             fits;

	// One restoring step: shift in the next dividend bit and try the subtraction.
	always_comb begin
		rem_shift = {rem_q, quo_q[W-1]};
		rem_diff  = rem_shift - {1'b0, divisor_q};
		fits      = rem_shift >= {1'b0, divisor_q};
	end

	// The step counter is the only control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// Quotient bits enter from the right as the dividend bits leave at the left.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q     <= dividend;
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[W-2:0], fits};
			rem_q <= fits ? W'(rem_diff) : W'(rem_shift);
		end
	end

	assign busy      = start || (cnt_q != '0);
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

### hdl/nearest_downsample_gray_core.sv
// -----------------------------------------------------------------------------
// nearest_downsample_gray_core
// Nearest-neighbor downscaler that turns a raster RGB stream into gray pixels.
// -----------------------------------------------------------------------------
// The core takes one source pixel per clock in raster order whenever its input
// is ready, and emits the pixels that the nearest-neighbor grid samples, each
// as floor((r+g+b)/3), with frame_end set on the last output pixel of a
// frame. A sampled pixel passes through the first stage register and then
// the output register. The column and row step sizes (source size divided
// by output size) are found by two one-bit-per-cycle dividers after reset
// and after every register write; while they run the input is not ready.
// Any register write restarts the frame at pixel (0,0).
// Sizes of zero count as one, sizes above MAX_DIMENSION saturate, and an
// output size larger than the source size is taken as the source size.
module nearest_downsample_gray_core #(
	parameter int MAX_DIMENSION = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ndg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ndg_pkg::CFG_W-1:0]     cfg_data,
	ndg_rgb_if.sink                       rgb,
	ndg_mono_if.source                    mono
);

	localparam int CFG_MAX = (1 << ndg_pkg::CFG_W) - 1;
	localparam int CLAMP   = (MAX_DIMENSION < CFG_MAX) ? MAX_DIMENSION : CFG_MAX;
	localparam int DIM_W   = $clog2(CLAMP + 1);
	localparam int CNT_W   = (CLAMP > 2) ? $clog2(CLAMP) : 1;

	// Size registers as written.
	logic [ndg_pkg::CFG_W-1:0] src_width_q, src_height_q, dst_width_q, dst_height_q;

	// Effective sizes and step sizes.
	logic [DIM_W-1:0] sw, sh, dw_raw, dh_raw, dw, dh;
	logic [DIM_W-1:0] cq, cr, rq, rr;
	logic             div_start_q, col_busy, row_busy, div_busy;

	// Position state.
	logic [CNT_W-1:0] src_col_q, src_row_q;
	logic [DIM_W-1:0] out_col_q, out_row_q;
	logic [DIM_W-1:0] col_tgt_q, col_rem_q, row_tgt_q, row_rem_q;

	// Step logic.
	logic             col_hit, row_hit, col_end, row_end, frame_end;
	logic [DIM_W:0]   col_rsum, row_rsum;
	logic             col_carry, row_carry;
	logic [DIM_W-1:0] col_rem_nxt, row_rem_nxt, col_tgt_nxt, row_tgt_nxt;

	// Pipeline.
	logic                            accept, adv2;
	logic                            s1_valid;
	ndg_pkg::sample_t                sample_s1;
	logic [ndg_pkg::SUM_W-1:0]       sum;
	logic [ndg_pkg::PROD_W-1:0]      prod;
	logic                            s2_valid;
	logic [ndg_pkg::CHAN_W-1:0]      gray_s2;
	logic                            frame_end_s2;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [ndg_pkg::CFG_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (32'(v) > 32'(CLAMP)) begin
			r = DIM_W'(CLAMP);
		end else begin
			r = DIM_W'(v);
		end
		return r;
	endfunction

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= ndg_pkg::SRC_WIDTH_RST;
			src_height_q <= ndg_pkg::SRC_HEIGHT_RST;
			dst_width_q  <= ndg_pkg::DST_WIDTH_RST;
			dst_height_q <= ndg_pkg::DST_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (ndg_pkg::cfg_reg_t'(cfg_index))
				ndg_pkg::REG_SRC_WIDTH:  src_width_q  <= cfg_data;
				ndg_pkg::REG_SRC_HEIGHT: src_height_q <= cfg_data;
				ndg_pkg::REG_DST_WIDTH:  dst_width_q  <= cfg_data;
				ndg_pkg::REG_DST_HEIGHT: dst_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp the sizes and keep the output no larger than the source.
	always_comb begin
		sw     = clamp_dim(src_width_q);
		sh     = clamp_dim(src_height_q);
		dw_raw = clamp_dim(dst_width_q);
		dh_raw = clamp_dim(dst_height_q);
		dw     = (dw_raw > sw) ? sw : dw_raw;
		dh     = (dh_raw > sh) ? sh : dh_raw;
	end

	// Step sizes are recomputed after reset and after every register write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_start_q <= 1'b1;
		end else begin
			div_start_q <= cfg_we;
		end
	end

	ndg_divider #(.W(DIM_W)) u_col_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start_q),
		.dividend  (sw),
		.divisor   (dw),
		.busy      (col_busy),
		.quotient  (cq),
		.remainder (cr)
	);

	ndg_divider #(.W(DIM_W)) u_row_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start_q),
		.dividend  (sh),
		.divisor   (dh),
		.busy      (row_busy),
		.quotient  (rq),
		.remainder (rr)
	);

	assign div_busy = col_busy || row_busy;

	// Sample test and the next column and row targets.
	always_comb begin
		col_hit   = (DIM_W'(src_col_q) == col_tgt_q) && (out_col_q < dw);
		row_hit   = (DIM_W'(src_row_q) == row_tgt_q) && (out_row_q < dh);
		col_end   = ({1'b0, DIM_W'(src_col_q)} + (DIM_W+1)'(1)) >= {1'b0, sw};
		row_end   = ({1'b0, DIM_W'(src_row_q)} + (DIM_W+1)'(1)) >= {1'b0, sh};
		frame_end = (out_col_q == dw - DIM_W'(1)) && (out_row_q == dh - DIM_W'(1));

		col_rsum    = {1'b0, col_rem_q} + {1'b0, cr};
		col_carry   = col_rsum >= {1'b0, dw};
		col_rem_nxt = col_carry ? DIM_W'(col_rsum - {1'b0, dw}) : DIM_W'(col_rsum);
		col_tgt_nxt = col_tgt_q + cq + DIM_W'(col_carry);

		row_rsum    = {1'b0, row_rem_q} + {1'b0, rr};
		row_carry   = row_rsum >= {1'b0, dh};
		row_rem_nxt = row_carry ? DIM_W'(row_rsum - {1'b0, dh}) : DIM_W'(row_rsum);
		row_tgt_nxt = row_tgt_q + rq + DIM_W'(row_carry);
	end

	// Handshake: with the dividers idle, the first stage takes a pixel when it
	// can pass its contents on, so one waiting result does not stall the input.
	assign adv2      = !s2_valid || mono.ready;
	assign rgb.ready = !div_busy && (!s1_valid || adv2);
	assign accept    = rgb.valid && rgb.ready;

	// Position counters advance on every transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_col_q <= '0;
			src_row_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			col_tgt_q <= '0;
			col_rem_q <= '0;
			row_tgt_q <= '0;
			row_rem_q <= '0;
		end else if (cfg_we) begin
			src_col_q <= '0;
			src_row_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			col_tgt_q <= '0;
			col_rem_q <= '0;
			row_tgt_q <= '0;
			row_rem_q <= '0;
		end else if (accept) begin
			if (col_end) begin
				src_col_q <= '0;
				out_col_q <= '0;
				col_tgt_q <= '0;
				col_rem_q <= '0;
				if (row_end) begin
					src_row_q <= '0;
					out_row_q <= '0;
					row_tgt_q <= '0;
					row_rem_q <= '0;
				end else begin
					src_row_q <= src_row_q + CNT_W'(1);
					if (row_hit) begin
						out_row_q <= out_row_q + DIM_W'(1);
						row_tgt_q <= row_tgt_nxt;
						row_rem_q <= row_rem_nxt;
					end
				end
			end else begin
				src_col_q <= src_col_q + CNT_W'(1);
				if (col_hit) begin
					out_col_q <= out_col_q + DIM_W'(1);
					col_tgt_q <= col_tgt_nxt;
					col_rem_q <= col_rem_nxt;
				end
			end
		end
	end

	// Pipeline valid bits: only sampled pixels enter the first stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			s2_valid <= 1'b0;
		end else begin
			if (accept && col_hit && row_hit) begin
				s1_valid <= 1'b1;
			end else if (adv2) begin
				s1_valid <= 1'b0;
			end
			if (adv2) begin
				s2_valid <= s1_valid;
			end
		end
	end

	// First stage holds the sampled pixel.
	always_ff @(posedge clk) begin
		if (accept && col_hit && row_hit) begin
			sample_s1.red       <= rgb.red;
			sample_s1.green     <= rgb.green;
			sample_s1.blue      <= rgb.blue;
			sample_s1.frame_end <= frame_end;
		end
	end

	// Gray value: sum of the channels times a reciprocal of three.
	always_comb begin
		sum  = ndg_pkg::SUM_W'(sample_s1.red) + ndg_pkg::SUM_W'(sample_s1.green)
			+ ndg_pkg::SUM_W'(sample_s1.blue);
		prod = ndg_pkg::PROD_W'(sum) * ndg_pkg::PROD_W'(ndg_pkg::RECIP3);
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (adv2 && s1_valid) begin
			gray_s2      <= ndg_pkg::CHAN_W'(prod >> ndg_pkg::RECIP3_SHIFT);
			frame_end_s2 <= sample_s1.frame_end;
		end
	end

	assign mono.valid     = s2_valid;
	assign mono.gray      = gray_s2;
	assign mono.frame_end = frame_end_s2;

`ifndef SYNTHESIS
	// No pixel is taken while the step sizes are being computed.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !div_busy)
		else $error("pixel accepted during step size computation");

	// The source column always lies inside the source row.
	assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, DIM_W'(src_col_q)} < {1'b0, sw})
		else $error("source column beyond source width");

	// Column and row remainders stay below their divisors.
	assert property (@(posedge clk) disable iff (!arst_n)
		(col_rem_q < dw) && (row_rem_q < dh))
		else $error("target remainder out of range");

	// Output counts never pass the output size.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_col_q <= dw) && (out_row_q <= dh))
		else $error("output count beyond output size");

	// With both stages full and the output stalled, the input must hold off.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && s2_valid && !mono.ready) |-> !rgb.ready)
		else $error("input ready while pipeline is full");
`endif

endmodule

### bench/tb.sv
// -----------------------------------------------------------------------------
// tb
// Self-checking bench for the nearest-neighbor gray downscaler core.
// -----------------------------------------------------------------------------
// A table of directed rows exercises the reset sizes, zero sizes, saturated and
// upscale sizes, a mid-frame restart and a frame wrap. A long run of random
// frame geometries follows, with random pixels. Every accepted source pixel is
// run through a local model of the sampling grid. Each gray pixel that the core
// sends out is compared with the oldest pixel still due. Both channels stall at
// random, and some stretches run at full rate.
module tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_DIM        = 4096;
	localparam int SETTLE_CYCLES  = 4;
	localparam int TAIL_CYCLES    = 8;
	localparam int RANDOM_PIXELS  = 1550;
	localparam int HOLD_AT_PIXEL  = 600;
	localparam int SCRIPT_LEN     = 38;
	localparam int REPORT_LIMIT   = 10;

	// Short names for the register indexes in the directed table.
	localparam ndg_pkg::cfg_reg_t R_SRC_W = ndg_pkg::REG_SRC_WIDTH;
	localparam ndg_pkg::cfg_reg_t R_SRC_H = ndg_pkg::REG_SRC_HEIGHT;
	localparam ndg_pkg::cfg_reg_t R_DST_W = ndg_pkg::REG_DST_WIDTH;
	localparam ndg_pkg::cfg_reg_t R_DST_H = ndg_pkg::REG_DST_HEIGHT;

	typedef logic [ndg_pkg::CFG_W-1:0]  dim_t;
	typedef logic [ndg_pkg::CHAN_W-1:0] chan_t;

	// One gray output pixel as the core should send it.
	typedef struct packed {
		chan_t gray;
		logic  frame_end;
	} gray_px_t;

	typedef enum {ROW_PIXEL, ROW_WRITE} row_kind_t;
	typedef enum {BY_PREDICTOR, NO_GRAY, GIVEN_GRAY} row_check_t;

	typedef struct {
		row_kind_t         kind;
		ndg_pkg::cfg_reg_t index;
		dim_t              value;
		chan_t             red;
		chan_t             green;
		chan_t             blue;
		row_check_t        check;
		chan_t             gray;
		logic              frame_end;
	} script_row_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	ndg_pkg::cfg_reg_t cfg_index;
	dim_t              cfg_data;

	ndg_rgb_if  rgb ();
	ndg_mono_if mono ();

	nearest_downsample_gray_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rgb       (rgb),
		.mono      (mono)
	);

	// Size registers and raster position of the local model.
	dim_t size_reg [4];
	dim_t src_col, src_row, out_col, out_row;
	dim_t col_goal, col_rem, row_goal, row_rem;

	gray_px_t gray_due [$];
	int       mismatches = 0;
	bit       calm = 1'b0;
	int       stall_left = 0;

	// Directed rows: sizes after reset, the one-pixel frame, saturated
	// sizes with a restart in mid-frame, an upscale request, and a wrap.
	script_row_t script [SCRIPT_LEN] = '{
		'{ROW_PIXEL, R_SRC_W, 13'd0,    8'd255, 8'd255, 8'd255, GIVEN_GRAY,   8'd255, 1'b0},
		'{ROW_PIXEL, R_SRC_W, 13'd0,    8'd0,   8'd0,   8'd0,   NO_GRAY,      8'd0,   1'b0},
		'{ROW_WRITE, R_SRC_W, 13'd0,    8'd0,   8'd0,   8'd0,   NO_GRAY,      8'd0,   1'b0},
		'{ROW_WRITE, R_SRC_H, 13'd0,    8'd0,   8'd0,   8'd0,   NO_GRAY,      8'd0,   1'b0},
		'{ROW_WRITE, R_DST_W, 13'd0,    8'd0,   8'd0,   8'd0,   NO_GRAY,      8'd0,   1'b0},
		'{ROW_WRITE, R_DST_H, 13'd0,    8'd0,   8'd0,   8'd0,   NO_GRAY,      8'd0,   1'b0},
		'{ROW_PIXEL, R_SRC_W, 13'd0,    8'd0,   8'd0,   8'd0,   GIVEN_GRAY,   8'd0,   1'b1},
		'{ROW_PIXEL, R_SRC_W, 13'd0,    8'd255, 8'd255, 8'd255, GIVEN_GRAY,   8'd255, 1'b1},
		'{ROW_PIXEL, R_SRC_W, 13'd0,    8'd1,   8'd1,   8'd0,   GIVEN_GRAY,   8'd0,   1'b1},
		'{ROW_PIXEL, R_SRC_W, 13'd0,    8'd2,   8'd2,   8'd1,   GIVEN_GRAY,   8'd1,   1'b1},
		'{ROW_PIXEL, R_SRC_W, 13'd0,    8'd255, 8'd255, 8'd254, GIVEN_GRAY,   8'd254, 1'b1},
		'{ROW_WRITE, R_SRC_W, 13'd8191, 8'd0,   8'd0,   8'd0,   NO_GRAY,      8'd0,   1'b0},
		'{ROW_WRITE, R_DST_W, 13'd8191, 8'd0,   8'd0,   8'd0,   NO_GRAY,      8'd0,   1'b0},
		'{ROW_PIXEL, R_SRC_W, 13'd0,    8'd128, 8'd64,  8'd32,  GIVEN_GRAY,   8'd74,  1'b0},
		'{ROW_PIXEL, R_SRC_W, 13'd0,    8'd15,  8'd240, 8'd85,  BY_PREDICTOR, 8'd0,   1'b0},
		'{ROW_WRITE, R_SRC_W, 13'd3,    8'd0,   8'd0,   8'd0,   NO_GRAY,      8'd0,   1'b0},
		'{ROW_WRITE, R_SRC_H, 13'd2,    8'd0,   8'd0,   8'd0,   NO_GRAY,      8'd0,   1'b0},
		'{ROW_WRITE, R_DST_W, 13'd5,    8'd0,   8'd0,   8'd0,   NO_GRAY,      8'd0,   1'b0},
		'{ROW_WRITE, R_DST_H, 13'd9,    8'd0,   8'd0,   8'd0,   NO_GRAY,      8'd0,   1'b0},
		'{ROW_PIXEL, R_SRC_W, 13'd0,    8'd1,   8'd2,   8'd3,   BY_PREDICTOR, 8'd0,   1'b0},
		'{ROW_PIXEL, R_SRC_W, 13'd0,    8'd254, 8'd253, 8'd252, BY_PREDICTOR, 8'd0,   1'b0},
		'{ROW_PIXEL, R_SRC_W, 13'd0,    8'd0,   8'd255, 8'd0,   BY_PREDICTOR, 8'd0,   1'b0},
		'{ROW_PIXEL, R_SRC_W, 13'd0,    8'd170, 8'd170, 8'd171, BY_PREDICTOR, 8'd0,   1'b0},
		'{ROW_PIXEL, R_SRC_W, 13'd0,    8'd85,  8'd0,   8'd0,   BY_PREDICTOR, 8'd0,   1'b0},
		'{ROW_PIXEL, R_SRC_W, 13'd0,    8'd255, 8'd0,   8'd255, BY_PREDICTOR, 8'd0,   1'b0},
		'{ROW_WRITE, R_SRC_H, 13'd3,    8'd0,   8'd0,   8'd0,   NO_GRAY,      8'd0,   1'b0},
		'{ROW_WRITE, R_DST_W, 13'd2,    8'd0,   8'd0,   8'd0,   NO_GRAY,      8'd0,   1'b0},
		'{ROW_WRITE, R_DST_H, 13'd2,    8'd0,   8'd0,   8'd0,   NO_GRAY,      8'd0,   1'b0},
		'{ROW_PIXEL, R_SRC_W, 13'd0,    8'd10,  8'd20,  8'd30,  BY_PREDICTOR, 8'd0,   1'b0},
		'{ROW_PIXEL, R_SRC_W, 13'd0,    8'd40,  8'd50,  8'd60,  BY_PREDICTOR, 8'd0,   1'b0},
		'{ROW_PIXEL, R_SRC_W, 13'd0,    8'd70,  8'd80,  8'd90,  BY_PREDICTOR, 8'd0,   1'b0},
		'{ROW_PIXEL, R_SRC_W, 13'd0,    8'd100, 8'd110, 8'd120, BY_PREDICTOR, 8'd0,   1'b0},
		'{ROW_PIXEL, R_SRC_W, 13'd0,    8'd130, 8'd140, 8'd150, BY_PREDICTOR, 8'd0,   1'b0},
		'{ROW_PIXEL, R_SRC_W, 13'd0,    8'd160, 8'd170, 8'd180, BY_PREDICTOR, 8'd0,   1'b0},
		'{ROW_PIXEL, R_SRC_W, 13'd0,    8'd190, 8'd200, 8'd210, BY_PREDICTOR, 8'd0,   1'b0},
		'{ROW_PIXEL, R_SRC_W, 13'd0,    8'd220, 8'd230, 8'd240, BY_PREDICTOR, 8'd0,   1'b0},
		'{ROW_PIXEL, R_SRC_W, 13'd0,    8'd250, 8'd251, 8'd252, BY_PREDICTOR, 8'd0,   1'b0},
		'{ROW_PIXEL, R_SRC_W, 13'd0,    8'd7,   8'd8,   8'd9,   BY_PREDICTOR, 8'd0,   1'b0}
	};

	// Free-running clock with an 8 ns period.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Now and then switch between stalling at random and running at full rate.
	always @(posedge clk) begin
		if ($urandom_range(0, 399) == 0) calm <= !calm;
	end

	// Size of a random pause: mostly none or short, now and then long.
	function automatic int unsigned pick_pause();
		int unsigned p;
		if (calm) return 0;
		p = $urandom_range(0, 99);
		if (p < 65) return 0;
		if (p < 90) return $urandom_range(1, 3);
		if (p < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// A register value of zero counts as one, and large values saturate.
	function automatic dim_t clip_size(input dim_t v);
		if (v == 0) return 1;
		if (v > MAX_DIM) return dim_t'(MAX_DIM);
		return v;
	endfunction

	function automatic void clear_position();
		src_col  = '0;
		src_row  = '0;
		out_col  = '0;
		out_row  = '0;
		col_goal = '0;
		col_rem  = '0;
		row_goal = '0;
		row_rem  = '0;
	endfunction

	// Advances the sampling grid by one source pixel. Returns 1 when the
	// pixel is sampled, with the gray value and frame-end mark in px.
	function automatic bit downscale_step(input chan_t r, input chan_t g, input chan_t b,
			output gray_px_t px);
		dim_t                       sw, sh, dw, dh, cq, cr, rq, rr;
		logic [ndg_pkg::CHAN_W+1:0] sum;
		bit                         col_hit, row_hit;
		sw = clip_size(size_reg[ndg_pkg::REG_SRC_WIDTH]);
		sh = clip_size(size_reg[ndg_pkg::REG_SRC_HEIGHT]);
		dw = clip_size(size_reg[ndg_pkg::REG_DST_WIDTH]);
		dh = clip_size(size_reg[ndg_pkg::REG_DST_HEIGHT]);
		if (dw > sw) dw = sw;
		if (dh > sh) dh = sh;
		cq = sw / dw;
		cr = sw % dw;
		rq = sh / dh;
		rr = sh % dh;

		sum          = {2'b00, r} + {2'b00, g} + {2'b00, b};
		px.gray      = chan_t'(sum / 3);
		px.frame_end = (out_col == dw - 1) && (out_row == dh - 1);
		col_hit      = (src_col == col_goal) && (out_col < dw);
		row_hit      = (src_row == row_goal) && (out_row < dh);

		// The column target moves on by the quotient after each hit, plus one on a remainder carry.
		if (col_hit) begin
			out_col  = out_col + 1;
			col_goal = col_goal + cq;
			col_rem  = col_rem + cr;
			if (col_rem >= dw) begin
				col_rem  = col_rem - dw;
				col_goal = col_goal + 1;
			end
		end

		// At the end of a source row, step the row target and maybe wrap.
		if (src_col + 1 >= sw) begin
			src_col  = '0;
			out_col  = '0;
			col_goal = '0;
			col_rem  = '0;
			if (row_hit) begin
				out_row  = out_row + 1;
				row_goal = row_goal + rq;
				row_rem  = row_rem + rr;
				if (row_rem >= dh) begin
					row_rem  = row_rem - dh;
					row_goal = row_goal + 1;
				end
			end
			src_row = src_row + 1;
			if (src_row >= sh) clear_position();
		end else begin
			src_col = src_col + 1;
		end
		return col_hit && row_hit;
	endfunction

	function automatic void flag_error(input string msg);
		mismatches++;
		if (mismatches <= REPORT_LIMIT) $display("ERROR at %0t: %s", $realtime, msg);
	endfunction

	// Offers one source pixel after a random gap and waits for its transfer.
	task automatic send_pixel(input chan_t r, input chan_t g, input chan_t b,
			output bit hit, output gray_px_t px);
		int unsigned gap;
		gap = pick_pause();
		if (gap != 0) begin
			rgb.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rgb.valid <= 1'b1;
		rgb.red   <= r;
		rgb.green <= g;
		rgb.blue  <= b;
		do @(posedge clk); while (!rgb.ready);
		hit = downscale_step(r, g, b, px);
	endtask

	// Stops the source and waits until every due gray pixel has arrived.
	task automatic drain_output();
		rgb.valid <= 1'b0;
		wait (gray_due.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_size(input ndg_pkg::cfg_reg_t idx, input dim_t value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		size_reg[idx] = value;
		clear_position();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Source sizes stay small most of the time so that frames complete.
	function automatic dim_t rand_src_size();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 84) return dim_t'($urandom_range(1, 12));
		if (p < 90) return '0;
		if (p < 96) return dim_t'($urandom_range(13, 300));
		return dim_t'($urandom_range(4000, 8191));
	endfunction

	// Output sizes include zero, equal to the source, upscale and oversize.
	function automatic dim_t rand_dst_size(input dim_t src);
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 60) return dim_t'($urandom_range(1, 12));
		if (p < 72) return src;
		if (p < 82) return '0;
		if (p < 92) return dim_t'($urandom_range(13, 40));
		return dim_t'($urandom_range(4097, 8191));
	endfunction

	task automatic pick_sizes();
		logic [3:0] mask;
		mask = 4'($urandom_range(1, 15));
		if (mask[0]) write_size(ndg_pkg::REG_SRC_WIDTH, rand_src_size());
		if (mask[1]) write_size(ndg_pkg::REG_SRC_HEIGHT, rand_src_size());
		if (mask[2]) write_size(ndg_pkg::REG_DST_WIDTH,
			rand_dst_size(size_reg[ndg_pkg::REG_SRC_WIDTH]));
		if (mask[3]) write_size(ndg_pkg::REG_DST_HEIGHT,
			rand_dst_size(size_reg[ndg_pkg::REG_SRC_HEIGHT]));
	endtask

	function automatic chan_t rand_chan();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 5) return '0;
		if (p < 10) return '1;
		return chan_t'($urandom_range(0, 255));
	endfunction

	// The sink stalls at random, holding ready low for the chosen length.
	always @(posedge clk) begin
		int unsigned pause;
		if (stall_left != 0) begin
			mono.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			pause = pick_pause();
			if (pause != 0) begin
				mono.ready <= 1'b0;
				stall_left <= pause - 1;
			end else begin
				mono.ready <= 1'b1;
			end
		end
	end

	// Each gray transfer is checked against the oldest pixel due.
	always @(posedge clk) begin
		gray_px_t want;
		if (mono.valid && mono.ready) begin
			if (gray_due.size() == 0) begin
				flag_error($sformatf("gray %0d frame_end %0b arrived with no pixel due",
					mono.gray, mono.frame_end));
			end else begin
				want = gray_due.pop_front();
				if (mono.gray !== want.gray)
					flag_error($sformatf("gray: expected %0d, got %0d", want.gray, mono.gray));
				if (mono.frame_end !== want.frame_end)
					flag_error($sformatf("frame_end: expected %0b, got %0b",
						want.frame_end, mono.frame_end));
			end
		end
	end

	// Stimulus: reset, the directed table, then random frame geometries.
	initial begin
		bit          hit;
		gray_px_t    px;
		int unsigned sent;
		int unsigned burst;
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = ndg_pkg::REG_SRC_WIDTH;
		cfg_data   = '0;
		rgb.valid  = 1'b0;
		rgb.red    = '0;
		rgb.green  = '0;
		rgb.blue   = '0;
		mono.ready = 1'b0;
		size_reg[ndg_pkg::REG_SRC_WIDTH]  = ndg_pkg::SRC_WIDTH_RST;
		size_reg[ndg_pkg::REG_SRC_HEIGHT] = ndg_pkg::SRC_HEIGHT_RST;
		size_reg[ndg_pkg::REG_DST_WIDTH]  = ndg_pkg::DST_WIDTH_RST;
		size_reg[ndg_pkg::REG_DST_HEIGHT] = ndg_pkg::DST_HEIGHT_RST;
		clear_position();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (script[i]) begin
			if (script[i].kind == ROW_WRITE) begin
				drain_output();
				write_size(script[i].index, script[i].value);
			end else begin
				send_pixel(script[i].red, script[i].green, script[i].blue, hit, px);
				case (script[i].check)
					BY_PREDICTOR: if (hit) gray_due.push_back(px);
					GIVEN_GRAY:   gray_due.push_back('{script[i].gray, script[i].frame_end});
					default: ;
				endcase
			end
		end

		// Random phases: new sizes while idle, then a burst of pixels.
		sent = 0;
		while (sent < RANDOM_PIXELS) begin
			drain_output();
			pick_sizes();
			burst = $urandom_range(20, 120);
			repeat (burst) begin
				if (sent == HOLD_AT_PIXEL || $urandom_range(0, 199) == 0) drain_output();
				send_pixel(rand_chan(), rand_chan(), rand_chan(), hit, px);
				if (hit) gray_due.push_back(px);
				sent++;
			end
		end

		rgb.valid <= 1'b0;
		wait (gray_due.size() == 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

	// Watchdog for a core that hangs or drops pixels.
	initial begin
		#8_000_000;
		$display("tb failed");
		$finish;
	end

endmodule

### nearest_downsample_gray_core.f
hdl/ndg_pkg.sv
hdl/ndg_rgb_if.sv
hdl/ndg_mono_if.sv
hdl/ndg_divider.sv
hdl/nearest_downsample_gray_core.sv
bench/tb.sv
